FILE: rtl/jepc_pkg.sv
// Shared types, constants and helpers for the Julia escape-time colouriser.
package jepc_pkg;

    localparam int FRAC_BITS = 26;
    localparam logic [7:0] LVL_FULL  = 8'd235;
    localparam logic [7:0] LVL_FLOOR = 8'd19;
    localparam logic [63:0] ESC_THRESH = 64'd4 << (2 * FRAC_BITS);

    localparam logic [2:0] CFG_CENTER_RE  = 3'd0;
    localparam logic [2:0] CFG_CENTER_IM  = 3'd1;
    localparam logic [2:0] CFG_PIXEL_STEP = 3'd2;
    localparam logic [2:0] CFG_CONST_RE   = 3'd3;
    localparam logic [2:0] CFG_CONST_IM   = 3'd4;

    typedef struct packed {
        logic signed [31:0] center_re;
        logic signed [31:0] center_im;
        logic [30:0]        pixel_step;
        logic signed [31:0] const_re;
        logic signed [31:0] const_im;
    } cfg_t;

    typedef struct packed {
        logic load_px;
        logic map;
        logic init;
        logic mul;
        logic step;
        logic take_esc;
        logic take_bnd;
        logic col;
        logic div;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic esc_hit;
        logic itr_full;
    } sts_t;

    typedef struct packed {
        logic [9:0] escape_count;
        logic       escaped;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pay_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

FILE: rtl/jepc_if.sv
// Request channel interfaces: pixel input, result output and configuration writes.
interface jepc_pix_if;
    logic       valid;
    logic       ready;
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface jepc_res_if;
    logic       valid;
    logic       ready;
    logic [9:0] escape_count;
    logic       escaped;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, output escape_count, output escaped,
                    output red, output green, output blue, input ready);
    modport sink   (input valid, input escape_count, input escaped,
                    input red, input green, input blue, output ready);
endinterface

interface jepc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/jepc_datapath.sv
// Datapath: mapping, shared complex iteration multipliers, colour ramp by reciprocal multiply.
module jepc_datapath
    import jepc_pkg::*;
#(
    parameter int MAX_ITER   = 512,
    parameter int IMG_WIDTH  = 900,
    parameter int IMG_HEIGHT = 600
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  cfg_t       cfg,
    input  logic [9:0] pixel_x,
    input  logic [9:0] pixel_y,
    output sts_t       sts,
    output pay_t       pay
);

    localparam int CW = $clog2(MAX_ITER + 1);
    localparam int TW = CW + 3;
    localparam logic signed [13:0] W14 = 14'(IMG_WIDTH);
    localparam logic signed [13:0] H14 = 14'(IMG_HEIGHT);
    localparam logic [TW-1:0] M1 = TW'(MAX_ITER);
    localparam logic [TW-1:0] M2 = TW'(2 * MAX_ITER);
    localparam logic [TW-1:0] M3 = TW'(3 * MAX_ITER);
    localparam logic [TW-1:0] M4 = TW'(4 * MAX_ITER);
    localparam logic [TW-1:0] M5 = TW'(5 * MAX_ITER);
    // ramp level = floor(255*(34g + 3*MAX_ITER) / (40*MAX_ITER))
    localparam logic [17:0] DIVISOR = 18'(40 * MAX_ITER);
    localparam logic [25:0] OFFSET  = 26'(3 * MAX_ITER);
    localparam int          RSH     = 43;
    localparam logic [33:0] RECIP   =
        34'(((64'd1 << RSH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [9:0]          px_reg, py_reg;
    logic signed [31:0]  re_reg, im_reg;
    logic signed [63:0]  p0_reg, p1_reg, p2_reg;
    logic [CW-1:0]       itr_reg, cnt_reg;
    logic                esc_reg;
    logic [2:0]          sec_reg;
    logic [25:0]         num_reg;
    logic [7:0]          q_reg;

    logic signed [13:0]  dx, dy;
    logic signed [31:0]  ma0, mb0, ma1, mb1;
    logic signed [63:0]  prod0, prod1, prod2;
    logic [63:0]         mag;
    logic [TW-1:0]       t, r, base;
    logic [2:0]          sec;
    logic [CW-1:0]       g;
    logic [25:0]         lin, num;
    logic [59:0]         qprod;

    assign dx = $signed({3'b000, px_reg, 1'b0}) - W14;
    assign dy = H14 - $signed({3'b000, py_reg, 1'b0});

    always_comb
    begin
        if (cmd.map)
        begin
            ma0 = 32'(dx);
            mb0 = $signed({1'b0, cfg.pixel_step});
            ma1 = 32'(dy);
            mb1 = $signed({1'b0, cfg.pixel_step});
        end
        else
        begin
            ma0 = re_reg;
            mb0 = re_reg;
            ma1 = im_reg;
            mb1 = im_reg;
        end
    end

    assign prod0 = ma0 * mb0;
    assign prod1 = ma1 * mb1;
    assign prod2 = re_reg * im_reg;

    assign mag = $unsigned(p0_reg) + $unsigned(p1_reg);
    assign sts.esc_hit  = (itr_reg != '0) && (mag > ESC_THRESH);
    assign sts.itr_full = (itr_reg == CW'(MAX_ITER));

    assign t = TW'(cnt_reg) * TW'(6);

    always_comb
    begin
        if (t >= M5)
            sec = 3'd5;
        else if (t >= M4)
            sec = 3'd4;
        else if (t >= M3)
            sec = 3'd3;
        else if (t >= M2)
            sec = 3'd2;
        else if (t >= M1)
            sec = 3'd1;
        else
            sec = 3'd0;
        if (sec >= 3'd4)
            base = M4;
        else if (sec >= 3'd2)
            base = M2;
        else
            base = '0;
    end

    assign r     = t - base;
    assign g     = (r > M1) ? CW'(M2 - r) : CW'(r);
    assign lin   = 26'(g) * 26'd34 + OFFSET;
    assign num   = (lin << 8) - lin;
    assign qprod = 60'(num_reg) * 60'(RECIP);

    always_ff @(posedge clk)
    begin
        if (cmd.load_px)
        begin
            px_reg <= pixel_x;
            py_reg <= pixel_y;
        end
        if (cmd.map || cmd.mul)
        begin
            p0_reg <= prod0;
            p1_reg <= prod1;
            p2_reg <= prod2;
        end
        if (cmd.init)
        begin
            re_reg <= sat32((p0_reg >>> 1) + 64'(cfg.center_re));
            im_reg <= sat32((p1_reg >>> 1) + 64'(cfg.center_im));
        end
        else if (cmd.step)
        begin
            re_reg <= sat32(((p0_reg - p1_reg) >>> FRAC_BITS) + 64'(cfg.const_re));
            im_reg <= sat32((p2_reg >>> (FRAC_BITS - 1)) + 64'(cfg.const_im));
        end
        if (cmd.col)
        begin
            sec_reg <= sec;
            num_reg <= num;
        end
        if (cmd.div)
            q_reg <= 8'(qprod >> RSH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            itr_reg <= '0;
            cnt_reg <= '0;
            esc_reg <= 1'b0;
        end
        else
        begin
            if (cmd.init)
                itr_reg <= '0;
            else if (cmd.step)
                itr_reg <= itr_reg + 1'b1;
            if (cmd.take_esc)
            begin
                cnt_reg <= itr_reg - 1'b1;
                esc_reg <= 1'b1;
            end
            else if (cmd.take_bnd)
            begin
                cnt_reg <= CW'(MAX_ITER);
                esc_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        pay.escape_count = 10'(cnt_reg);
        pay.escaped      = esc_reg;
        pay.red          = LVL_FLOOR;
        pay.green        = LVL_FLOOR;
        pay.blue         = LVL_FLOOR;
        if (esc_reg)
        begin
            case (sec_reg)
                3'd0:
                begin
                    pay.red = LVL_FULL;  pay.green = q_reg;     pay.blue = LVL_FLOOR;
                end
                3'd1:
                begin
                    pay.red = q_reg;     pay.green = LVL_FULL;  pay.blue = LVL_FLOOR;
                end
                3'd2:
                begin
                    pay.red = LVL_FLOOR; pay.green = LVL_FULL;  pay.blue = q_reg;
                end
                3'd3:
                begin
                    pay.red = LVL_FLOOR; pay.green = q_reg;     pay.blue = LVL_FULL;
                end
                3'd4:
                begin
                    pay.red = q_reg;     pay.green = LVL_FLOOR; pay.blue = LVL_FULL;
                end
                default:
                begin
                    pay.red = LVL_FULL;  pay.green = LVL_FLOOR; pay.blue = q_reg;
                end
            endcase
        end
    end

endmodule

FILE: rtl/jepc_ctrl.sv
// Controller state machine sequencing mapping, iterations and colouring.
module jepc_ctrl
    import jepc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic out_busy,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAP  = 3'd1;
    localparam logic [2:0] S_INIT = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_COL  = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_px = 1'b1;
                    state_next  = S_MAP;
                end
            end
            S_MAP:
            begin
                cmd.map    = 1'b1;
                state_next = S_INIT;
            end
            S_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (sts.esc_hit)
                begin
                    cmd.take_esc = 1'b1;
                    state_next   = S_COL;
                end
                else if (sts.itr_full)
                begin
                    cmd.take_bnd = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_COL:
            begin
                cmd.col    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    a_accept_maps: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_MAP))
        else $error("accepted request did not start mapping");
    a_esc_colour: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD && sts.esc_hit) |=> (state_reg == S_COL))
        else $error("escape did not start colouring");
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |=> (state_reg == S_DONE))
        else $error("ramp multiply took more than one cycle");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !out_busy)
        else $error("result emitted over a waiting result");
`endif

endmodule

FILE: rtl/julia_escape_pixel_colorizer.sv
// Top level: configuration registers, controller, datapath and result register.
//
// Use: a pixel request (pixel_x, pixel_y) enters on pix; one result request
// (escape_count, escaped, red, green, blue) leaves on res for each pixel.
// Configuration writes on cfg (index 0..4: center_re, center_im, pixel_step,
// const_re, const_im) are always ready; other indices are ignored.
// One pixel is processed at a time. Each iteration uses the shared
// multiplier set in turn: multiply, then update and magnitude test.
// Colouring of an escaped pixel forms a ramp numerator, then a reciprocal
// multiply. The result sits in an output register; pix is ready again as
// soon as the result is stored. If res stalls, a finished second pixel
// waits in the controller until the register frees.
// Reset restores the default view and Julia constant and clears all requests.
module julia_escape_pixel_colorizer
    import jepc_pkg::*;
#(
    parameter int MAX_ITER   = 512,
    parameter int IMG_WIDTH  = 900,
    parameter int IMG_HEIGHT = 600
)
(
    input logic         clk,
    input logic         rst_n,
    jepc_pix_if.sink    pix,
    jepc_res_if.source  res,
    jepc_cfg_if.sink    cfg
);

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;
    pay_t pay;
    pay_t out_reg;
    logic out_valid_reg;
    logic out_busy;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_re  <= 32'sd0;
            cfg_reg.center_im  <= 32'sd0;
            cfg_reg.pixel_step <= 31'd335544;
            cfg_reg.const_re   <= -32'sd56035901;
            cfg_reg.const_im   <= -32'sd15575967;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_CENTER_RE:  cfg_reg.center_re  <= cfg.data;
                CFG_CENTER_IM:  cfg_reg.center_im  <= cfg.data;
                CFG_PIXEL_STEP: cfg_reg.pixel_step <= cfg.data[30:0];
                CFG_CONST_RE:   cfg_reg.const_re   <= cfg.data;
                CFG_CONST_IM:   cfg_reg.const_im   <= cfg.data;
                default:        ;
            endcase
        end
    end

    assign out_busy = out_valid_reg && !res.ready;

    jepc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix.valid),
        .in_ready (pix.ready),
        .out_busy (out_busy),
        .sts      (sts),
        .cmd      (cmd)
    );

    jepc_datapath #(
        .MAX_ITER   (MAX_ITER),
        .IMG_WIDTH  (IMG_WIDTH),
        .IMG_HEIGHT (IMG_HEIGHT)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .cfg     (cfg_reg),
        .pixel_x (pix.pixel_x),
        .pixel_y (pix.pixel_y),
        .sts     (sts),
        .pay     (pay)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            out_reg <= pay;
    end

    assign res.valid        = out_valid_reg;
    assign res.escape_count = out_reg.escape_count;
    assign res.escaped      = out_reg.escaped;
    assign res.red          = out_reg.red;
    assign res.green        = out_reg.green;
    assign res.blue         = out_reg.blue;

endmodule

FILE: bench/julia_escape_pixel_colorizer_checker.sv
// Checker: watches the pixel, result and configuration channels, predicts each colour and compares.
module julia_escape_pixel_colorizer_checker
    import jepc_pkg::*;
#(
    parameter int MAX_ITER   = 512,
    parameter int IMG_WIDTH  = 900,
    parameter int IMG_HEIGHT = 600
)
(
    input  logic clk,
    input  logic rst_n,
    jepc_pix_if  pix,
    jepc_res_if  res,
    jepc_cfg_if  cfg,
    output int   fail_count,
    output int   colours_pending,
    output int   colours_seen,
    output int   escaped_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    cfg_t view;
    pay_t colour_queue[$];

    function automatic longint clamp_q626(input longint v);
        longint r;
        if (v > 64'sd2147483647)
            r = 64'sd2147483647;
        else if (v < -64'sd2147483648)
            r = -64'sd2147483648;
        else
            r = v;
        return r;
    endfunction

    function automatic pay_t colour_of(input logic [9:0] px, input logic [9:0] py);
        pay_t   p;
        longint re, im, nre, nim, step, mx, t, sector, r, g, x, count;
        logic [63:0] mag;
        bit     esc;
        step  = longint'(view.pixel_step);
        re    = clamp_q626((((2 * longint'(px)) - IMG_WIDTH) * step >>> 1)
                           + longint'(view.center_re));
        im    = clamp_q626(((IMG_HEIGHT - 2 * longint'(py)) * step >>> 1)
                           + longint'(view.center_im));
        count = MAX_ITER;
        esc   = 0;
        for (int i = 0; i < MAX_ITER; i++)
        begin
            nre = clamp_q626(((re * re - im * im) >>> FRAC_BITS) + longint'(view.const_re));
            nim = clamp_q626(((re * im) >>> (FRAC_BITS - 1)) + longint'(view.const_im));
            mag = 64'(nre * nre) + 64'(nim * nim);
            re  = nre;
            im  = nim;
            if (mag > ESC_THRESH)
            begin
                count = i;
                esc   = 1;
                break;
            end
        end
        p.escape_count = count[9:0];
        p.escaped      = esc;
        p.red          = LVL_FLOOR;
        p.green        = LVL_FLOOR;
        p.blue         = LVL_FLOOR;
        if (esc)
        begin
            mx     = MAX_ITER;
            t      = 6 * count;
            sector = t / mx;
            r      = t % (2 * mx);
            g      = mx - ((r > mx) ? r - mx : mx - r);
            x      = (255 * (4352 * g + 384 * mx)) / (5120 * mx);
            case (sector)
                0: begin p.red = LVL_FULL;  p.green = x[7:0];    p.blue = LVL_FLOOR; end
                1: begin p.red = x[7:0];    p.green = LVL_FULL;  p.blue = LVL_FLOOR; end
                2: begin p.red = LVL_FLOOR; p.green = LVL_FULL;  p.blue = x[7:0];    end
                3: begin p.red = LVL_FLOOR; p.green = x[7:0];    p.blue = LVL_FULL;  end
                4: begin p.red = x[7:0];    p.green = LVL_FLOOR; p.blue = LVL_FULL;  end
                default: begin p.red = LVL_FULL; p.green = LVL_FLOOR; p.blue = x[7:0]; end
            endcase
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pay_t want;
        if (!rst_n)
        begin
            view.center_re  <= 32'sd0;
            view.center_im  <= 32'sd0;
            view.pixel_step <= 31'd335544;
            view.const_re   <= -32'sd56035901;
            view.const_im   <= -32'sd15575967;
            colour_queue.delete();
            fail_count      <= 0;
            colours_pending <= 0;
            colours_seen    <= 0;
            escaped_seen    <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                colours_seen <= colours_seen + 1;
                if (colour_queue.size() == 0)
                begin
                    $error("result request with nothing outstanding");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = colour_queue.pop_front();
                    if (want.escaped)
                        escaped_seen <= escaped_seen + 1;
                    if (res.escape_count !== want.escape_count ||
                        res.escaped !== want.escaped || res.red !== want.red ||
                        res.green !== want.green || res.blue !== want.blue)
                        fail_count <= fail_count + 1;
                    if (res.escape_count !== want.escape_count)
                        $error("escape_count expected %0d got %0d",
                               want.escape_count, res.escape_count);
                    if (res.escaped !== want.escaped)
                        $error("escaped expected %0d got %0d", want.escaped, res.escaped);
                    if (res.red !== want.red)
                        $error("red expected %0d got %0d", want.red, res.red);
                    if (res.green !== want.green)
                        $error("green expected %0d got %0d", want.green, res.green);
                    if (res.blue !== want.blue)
                        $error("blue expected %0d got %0d", want.blue, res.blue);
                end
            end
            if (pix.valid && pix.ready)
                colour_queue.push_back(colour_of(pix.pixel_x, pix.pixel_y));
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_CENTER_RE:  view.center_re  <= cfg.data;
                    CFG_CENTER_IM:  view.center_im  <= cfg.data;
                    CFG_PIXEL_STEP: view.pixel_step <= cfg.data[30:0];
                    CFG_CONST_RE:   view.const_re   <= cfg.data;
                    CFG_CONST_IM:   view.const_im   <= cfg.data;
                    default: ;
                endcase
            end
        end
    end

    always @(negedge clk)
        colours_pending = colour_queue.size();

endmodule

FILE: bench/julia_escape_pixel_colorizer_tb.sv
// Testbench top: clock, reset, pixel and configuration stimulus, and the verdict.
module julia_escape_pixel_colorizer_tb;
    import jepc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CFG_UNUSED_A = 3'd5;
    localparam logic [2:0] CFG_UNUSED_B = 3'd7;

    logic clk;
    logic rst_n;
    logic calm;
    int   fail_count, colours_pending, colours_seen, escaped_seen;
    int   pixels_sent;

    jepc_pix_if pix();
    jepc_res_if res();
    jepc_cfg_if cfg();

    julia_escape_pixel_colorizer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix),
        .res   (res),
        .cfg   (cfg)
    );

    julia_escape_pixel_colorizer_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .pix             (pix),
        .res             (res),
        .cfg             (cfg),
        .fail_count      (fail_count),
        .colours_pending (colours_pending),
        .colours_seen    (colours_seen),
        .escaped_seen    (escaped_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else
            res.ready <= calm || ($urandom_range(99) >= 15);
    end

    task automatic send_pixel(input logic [9:0] x, input logic [9:0] y);
        while (!calm && $urandom_range(99) < 15)
        begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        pix.valid   <= 1'b1;
        pix.pixel_x <= x;
        pix.pixel_y <= y;
        do @(posedge clk); while (!pix.ready);
        pixels_sent++;
    endtask

    // leaves valid high; the caller drops it after the last write
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
    endtask

    task automatic drain;
        pix.valid <= 1'b0;
        @(posedge clk);
        while (colours_pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic random_pixels(input int n);
        logic [9:0] x, y;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(9) == 0)
            begin
                x = $urandom_range(1023);
                y = $urandom_range(1023);
            end
            else
            begin
                x = $urandom_range(899);
                y = $urandom_range(599);
            end
            send_pixel(x, y);
        end
    endtask

    task automatic set_view(input logic [31:0] cre, input logic [31:0] cim,
                            input logic [31:0] step, input logic [31:0] kre,
                            input logic [31:0] kim);
        write_reg(CFG_CENTER_RE, cre);
        write_reg(CFG_CENTER_IM, cim);
        write_reg(CFG_PIXEL_STEP, step);
        write_reg(CFG_CONST_RE, kre);
        write_reg(CFG_CONST_IM, kim);
        cfg.valid <= 1'b0;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        calm        = 1'b0;
        pixels_sent = 0;
        pix.valid   = 1'b0;
        pix.pixel_x = '0;
        pix.pixel_y = '0;
        cfg.valid   = 1'b0;
        cfg.index   = '0;
        cfg.data    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default view: corners, centre, axes and out-of-range coordinates
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd899, 10'd599);
        send_pixel(10'd450, 10'd300);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd449, 10'd301);
        send_pixel(10'd600, 10'd150);
        send_pixel(10'd200, 10'd450);
        send_pixel(10'd682, 10'd341);
        drain();

        // unknown indices are ignored
        write_reg(CFG_UNUSED_A, $urandom);
        write_reg(CFG_UNUSED_B, 32'hffffffff);
        cfg.valid <= 1'b0;
        send_pixel(10'd300, 10'd200);
        send_pixel(10'd700, 10'd500);
        drain();

        // saturating start points and iterates
        set_view(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd450, 10'd300);
        send_pixel(10'd899, 10'd0);
        drain();
        set_view(32'h7fffffff, 32'h80000000, 32'd0, 32'h80000000, 32'h7fffffff);
        send_pixel(10'd0, 10'd599);
        send_pixel(10'd512, 10'd512);
        drain();
        // zero step, origin, zero constant: stays bounded
        set_view(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        send_pixel(10'd123, 10'd456);
        drain();

        set_view(32'd0, 32'd0, 32'd335544, -32'sd56035901, -32'sd15575967);
        random_pixels(110);
        drain();

        set_view($urandom_range(67108864) - 33554432, $urandom_range(67108864) - 33554432,
                 $urandom_range(200000, 20000), $urandom_range(100663296) - 67108864,
                 $urandom_range(67108864) - 33554432);
        calm = 1'b1;
        random_pixels(100);
        calm = 1'b0;
        drain();

        set_view($urandom, $urandom, $urandom_range(32'h7fffffff), $urandom, $urandom);
        random_pixels(100);
        drain();

        set_view(32'd0, 32'd0, $urandom_range(700000, 200000),
                 $urandom_range(80000000) - 80000000, $urandom_range(60000000) - 30000000);
        random_pixels(100);
        drain();

        set_view($urandom_range(13421772) - 6710886, $urandom_range(13421772) - 6710886,
                 $urandom_range(40000, 1000), -32'sd56035901, -32'sd15575967);
        random_pixels(100);
        drain();

        set_view(32'h80000000, 32'h80000000, $urandom_range(1000), $urandom, $urandom);
        random_pixels(100);
        drain();

        $display("%0d pixels sent, %0d colours checked (%0d escaped) over several views",
                 pixels_sent, colours_seen, escaped_seen);
        if (fail_count == 0 && colours_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
rtl/jepc_pkg.sv
rtl/jepc_if.sv
rtl/jepc_datapath.sv
rtl/jepc_ctrl.sv
rtl/julia_escape_pixel_colorizer.sv
bench/julia_escape_pixel_colorizer_checker.sv
bench/julia_escape_pixel_colorizer_tb.sv
